// File: rtl/line_address_table_lookup_macros.svh
// assertion macros used by the checker file of the line/address lookup
`ifndef LINE_ADDRESS_TABLE_LOOKUP_MACROS_SVH
`define LINE_ADDRESS_TABLE_LOOKUP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LALT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lalt check failed");

// consequent must hold in the cycle after the antecedent
`define LALT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lalt check failed");

`endif

// File: rtl/lalt_pkg.sv
// shared types and constants of the line/address table lookup
package lalt_pkg;

	localparam int LINE_W          = 24;
	localparam int IDX_IN_W        = 8;
	localparam int CNT_IN_W        = 9;
	localparam int SLIDE_W         = 2;
	localparam int DEF_TABLE_DEPTH = 256;
	localparam int DEF_ADDR_WIDTH  = 32;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_WR_ADDR   = 2'd0,
		OP_WR_LINE   = 2'd1,
		OP_ADDR2LINE = 2'd2,
		OP_LINE2ADDR = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_TABLE_PRESENT = 2'd0,
		CFG_BASE_OFFSET   = 2'd1,
		CFG_ENTRY_COUNT   = 2'd2
	} cfg_idx_t;

	// search sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_PROBE,
		S_FETCH,
		S_DONE
	} state_t;

	// lookup start control handed to the search engine
	typedef struct packed {
		logic               start;
		logic               by_line;
		logic [SLIDE_W-1:0] slide;
	} lk_ctl_t;

endpackage

// File: rtl/lalt_ram.sv
// single-port-write, registered-read table memory
module lalt_ram #(
	parameter int DEPTH = lalt_pkg::DEF_TABLE_DEPTH,
	parameter int WIDTH = lalt_pkg::DEF_ADDR_WIDTH + lalt_pkg::LINE_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lalt_search.sv
// binary search sequencer reading one table entry per cycle
module lalt_search #(
	parameter int TABLE_DEPTH = lalt_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_WIDTH  = lalt_pkg::DEF_ADDR_WIDTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int KEY_W = (ADDR_WIDTH > lalt_pkg::LINE_W) ? ADDR_WIDTH : lalt_pkg::LINE_W,
	localparam int ENT_W = ADDR_WIDTH + lalt_pkg::LINE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lalt_pkg::lk_ctl_t           ctl,
	input  logic [KEY_W-1:0]            key,
	input  logic                        table_present,
	input  logic [ADDR_WIDTH-1:0]       base_offset,
	input  logic [CNT_W-1:0]            count,
	output logic                        idle,
	output logic [IDX_W-1:0]            raddr,
	input  logic [ENT_W-1:0]            rdata_a,
	input  logic [ENT_W-1:0]            rdata_l,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [lalt_pkg::LINE_W-1:0] res_line,
	output logic [ADDR_WIDTH-1:0]       res_addr
);
	import lalt_pkg::*;

	localparam int SW = CNT_W + 1;

	state_t                state_q, state_d;
	logic [KEY_W-1:0]      key_q;
	logic                  by_line_q;
	logic [SLIDE_W-1:0]    slide_q;
	logic signed [SW-1:0]  first_q, last_q;
	logic [IDX_W-1:0]      mid_q;
	logic [LINE_W-1:0]     res_line_q;
	logic [ADDR_WIDTH-1:0] res_addr_q;

	logic [ENT_W-1:0]      rdata;
	logic [ADDR_WIDTH-1:0] ent_addr;
	logic [LINE_W-1:0]     ent_line;
	logic [KEY_W-1:0]      ent_key;
	logic                  key_lt, key_gt;
	logic                  slide_pos, slide_neg, slide_zero;
	logic                  empty;
	logic [CNT_W-1:0]      cnt_m1;
	logic signed [SW-1:0]  last_init, mid_ext, first_n, last_n, miss_slot;
	logic signed [SW:0]    mid_sum;
	logic [IDX_W-1:0]      mid0, mid_n;
	logic                  go_on, miss_ok;
	logic                  ld_key, ld_bounds, ld_step, ld_res, res_zero;

	// entry under test
	assign rdata    = by_line_q ? rdata_l : rdata_a;
	assign ent_addr = rdata[ENT_W-1:LINE_W];
	assign ent_line = rdata[LINE_W-1:0];
	assign ent_key  = by_line_q ? KEY_W'(ent_line) : KEY_W'(ent_addr);
	assign key_lt   = key_q < ent_key;
	assign key_gt   = key_q > ent_key;

	// miss rule decode
	assign slide_neg  = slide_q[1];
	assign slide_pos  = !slide_q[1] && slide_q[0];
	assign slide_zero = (slide_q == '0);

	// bounds of the search window
	assign empty     = !table_present || (count == '0);
	assign cnt_m1    = count - CNT_W'(1);
	assign last_init = $signed(SW'(cnt_m1));
	assign mid0      = IDX_W'(cnt_m1 >> 1);
	assign mid_ext   = $signed(SW'(mid_q));

	// one halving step
	assign first_n   = key_lt ? first_q : mid_ext + $signed(SW'(1));
	assign last_n    = key_lt ? mid_ext - $signed(SW'(1)) : last_q;
	assign go_on     = first_n <= last_n;
	assign mid_sum   = $signed((SW + 1)'(first_n)) + $signed((SW + 1)'(last_n));
	assign mid_n     = IDX_W'(mid_sum[SW:1]);
	assign miss_slot = slide_pos ? last_n + $signed(SW'(1)) : last_n;
	assign miss_ok   = !slide_zero && (miss_slot >= $signed(SW'(0)))
		&& (miss_slot < $signed(SW'(count)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					state_d = empty ? S_DONE : S_FIRST;
				end
			end
			S_FIRST: begin
				state_d = key_lt ? S_DONE : S_LAST;
			end
			S_LAST: begin
				state_d = key_gt ? S_DONE : S_PROBE;
			end
			S_PROBE: begin
				if (!key_lt && !key_gt) begin
					state_d = S_DONE;
				end else if (go_on) begin
					state_d = S_PROBE;
				end else if (miss_ok) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FETCH: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// read address and datapath controls
	always_comb begin
		raddr     = '0;
		ld_key    = 1'b0;
		ld_bounds = 1'b0;
		ld_step   = 1'b0;
		ld_res    = 1'b0;
		res_zero  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ld_key = ctl.start;
				ld_res = ctl.start && empty;
				res_zero = 1'b1;
			end
			S_FIRST: begin
				raddr    = IDX_W'(cnt_m1);
				ld_res   = key_lt;
				res_zero = !slide_pos;
			end
			S_LAST: begin
				raddr     = mid0;
				ld_bounds = !key_gt;
				ld_res    = key_gt;
				res_zero  = !slide_neg;
			end
			S_PROBE: begin
				ld_step = 1'b1;
				if (!key_lt && !key_gt) begin
					ld_res = 1'b1;
				end else if (go_on) begin
					raddr = mid_n;
				end else if (miss_ok) begin
					raddr = IDX_W'(miss_slot);
				end else begin
					ld_res   = 1'b1;
					res_zero = 1'b1;
				end
			end
			S_FETCH: begin
				ld_res = 1'b1;
			end
			S_DONE: begin
				ld_res = 1'b0;
			end
			default: ld_res = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// lookup context, window and answer
	always_ff @(posedge clk) begin
		if (ld_key) begin
			key_q     <= key;
			by_line_q <= ctl.by_line;
			slide_q   <= ctl.slide;
		end
		if (ld_bounds) begin
			first_q <= '0;
			last_q  <= last_init;
			mid_q   <= mid0;
		end else if (ld_step) begin
			first_q <= first_n;
			last_q  <= last_n;
			mid_q   <= mid_n;
		end
		if (ld_res) begin
			res_line_q <= (res_zero || by_line_q) ? '0 : ent_line;
			res_addr_q <= (res_zero || !by_line_q) ? '0 : ent_addr + base_offset;
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_line  = res_line_q;
	assign res_addr  = res_addr_q;

endmodule

// File: rtl/line_address_table_lookup.sv
// Line/address table lookup. Two tables of (address, line) pairs, one sorted by
// address and one by line, live in two memories with a registered read. A table
// write gives no result. A lookup runs a floor-midpoint binary search through the
// read address shared by both memories, one entry per cycle: after the input
// transfer, the sequencer checks the first entry, then the last entry, then probes
// (at most ceil(log2(N+1)) probes for N entries, 9 for 256), then fetches a
// neighboring entry when a miss is resolved to one, and then hands the answer to the
// output register. A stalled result holds the sequencer. A new item is taken the
// cycle after the sequencer has handed its answer to the output register.
// The tables have no reset; only entries that were written may be looked up.
module line_address_table_lookup #(
	parameter int TABLE_DEPTH = lalt_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_WIDTH  = lalt_pkg::DEF_ADDR_WIDTH,
	localparam int CFG_W = (ADDR_WIDTH > lalt_pkg::CNT_IN_W) ? ADDR_WIDTH : lalt_pkg::CNT_IN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic [lalt_pkg::IDX_IN_W-1:0]       entry_index,
	input  logic [ADDR_WIDTH-1:0]               address,
	input  logic [lalt_pkg::LINE_W-1:0]         line_number,
	input  logic signed [lalt_pkg::SLIDE_W-1:0] slide_direction,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lalt_pkg::LINE_W-1:0]         found_line,
	output logic [ADDR_WIDTH-1:0]               found_address
);
	import lalt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = (ADDR_WIDTH > LINE_W) ? ADDR_WIDTH : LINE_W;
	localparam int ENT_W = ADDR_WIDTH + LINE_W;
	localparam int CMP_W = ((CNT_W > CNT_IN_W) ? CNT_W : CNT_IN_W) + 1;

	logic                  table_present_q;
	logic [ADDR_WIDTH-1:0] base_offset_q;
	logic [CNT_IN_W-1:0]   entry_count_q;
	logic [CNT_W-1:0]      eff_count;

	logic                  in_xfer, is_write, idx_ok, we_a, we_l;
	logic [IDX_W-1:0]      waddr, raddr;
	logic [ENT_W-1:0]      wdata, rdata_a, rdata_l;
	logic [ADDR_WIDTH-1:0] query_addr;
	logic [KEY_W-1:0]      key;
	lk_ctl_t               ctl;
	logic                  idle, res_valid, res_ready;
	logic [LINE_W-1:0]     res_line;
	logic [ADDR_WIDTH-1:0] res_addr;

	logic                  out_valid_q;
	logic [LINE_W-1:0]     found_line_q;
	logic [ADDR_WIDTH-1:0] found_address_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_present_q <= 1'b0;
			base_offset_q   <= '0;
			entry_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_PRESENT: table_present_q <= cfg_data[0];
				CFG_BASE_OFFSET:   base_offset_q   <= cfg_data[ADDR_WIDTH-1:0];
				CFG_ENTRY_COUNT:   entry_count_q   <= cfg_data[CNT_IN_W-1:0];
				default: ;
			endcase
		end
	end

	// entry count clamped to the table depth
	assign eff_count = (CMP_W'(entry_count_q) > CMP_W'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_q);

	// input transfer and table writes
	assign in_ready = idle;
	assign in_xfer  = in_valid && in_ready;
	assign is_write = (operation == OP_WR_ADDR) || (operation == OP_WR_LINE);
	assign idx_ok   = 32'(entry_index) < 32'(TABLE_DEPTH);
	assign we_a     = in_xfer && (operation == OP_WR_ADDR) && idx_ok;
	assign we_l     = in_xfer && (operation == OP_WR_LINE) && idx_ok;
	assign waddr    = IDX_W'(entry_index);
	assign wdata    = {address, line_number};

	// lookup key and start
	assign query_addr  = address - base_offset_q;
	assign ctl.start   = in_xfer && !is_write;
	assign ctl.by_line = (operation == OP_LINE2ADDR);
	assign ctl.slide   = slide_direction;
	assign key         = ctl.by_line ? KEY_W'(line_number) : KEY_W'(query_addr);

	lalt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENT_W)) u_addr_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	lalt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENT_W)) u_line_ram (
		.clk   (clk),
		.we    (we_l),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_l)
	);

	lalt_search #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_WIDTH(ADDR_WIDTH)) u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.key           (key),
		.table_present (table_present_q),
		.base_offset   (base_offset_q),
		.count         (eff_count),
		.idle          (idle),
		.raddr         (raddr),
		.rdata_a       (rdata_a),
		.rdata_l       (rdata_l),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_line      (res_line),
		.res_addr      (res_addr)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			found_line_q    <= res_line;
			found_address_q <= res_addr;
		end
	end

	assign out_valid     = out_valid_q;
	assign found_line    = found_line_q;
	assign found_address = found_address_q;

endmodule

// File: rtl/lalt_checker.sv
// port-level checks of the line/address table lookup, bound to the top level
`include "line_address_table_lookup_macros.svh"

module lalt_checker #(
	parameter int ADDR_WIDTH = lalt_pkg::DEF_ADDR_WIDTH
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  operation,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lalt_pkg::LINE_W-1:0] found_line,
	input logic [ADDR_WIDTH-1:0]       found_address
);
	import lalt_pkg::*;

	logic lookup_xfer;

	assign lookup_xfer = in_valid && in_ready
		&& ((operation == OP_ADDR2LINE) || (operation == OP_LINE2ADDR));

	// a result carries a line or an address, never both
	`LALT_ASSERT_SAME(a_one_answer, out_valid, (found_line == '0) || (found_address == '0))
	// a lookup keeps the block busy for the next cycle
	`LALT_ASSERT_NEXT(a_busy_after_lookup, lookup_xfer, !in_ready)
	// a new result only shows while a lookup was in flight
	`LALT_ASSERT_SAME(a_result_from_lookup, $rose(out_valid), !$past(in_ready))
	// a stalled result stays valid and holds its address
	`LALT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found_address))

endmodule

bind line_address_table_lookup lalt_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_lalt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.operation     (operation),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found_line    (found_line),
	.found_address (found_address)
);

// File: verif/line_address_table_lookup_tb.sv
// testbench of the line/address table lookup: random and directed traffic checked by a predictor
module line_address_table_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lalt_pkg::*;

	localparam int DEPTH       = DEF_TABLE_DEPTH;
	localparam int SETTLE      = 20;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [31:0] addr;
		logic [23:0] line;
	} entry_t;

	typedef struct {
		op_t               op;
		logic [7:0]        idx;
		logic [31:0]       addr;
		logic [23:0]       line;
		logic signed [1:0] slide;
	} req_t;

	typedef struct {
		logic [23:0] line;
		logic [31:0] addr;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	cfg_idx_t          cfg_index = CFG_TABLE_PRESENT;
	logic [31:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	op_t               operation = OP_WR_ADDR;
	logic [7:0]        entry_index = '0;
	logic [31:0]       address = '0;
	logic [23:0]       line_number = '0;
	logic signed [1:0] slide_direction = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [23:0]       found_line;
	logic [31:0]       found_address;

	// predictor state: table copies and register shadows
	entry_t      addr_tab [DEPTH];
	entry_t      line_tab [DEPTH];
	logic        cfg_present = 1'b0;
	logic [31:0] cfg_base = '0;
	logic [8:0]  cfg_count = '0;

	req_t        cmd_q [$];
	answer_t     answer_q [$];
	req_t        drv_cmd;
	logic        in_done = 1'b0;
	int          send_gap_pct = 0;
	int          recv_gap_pct = 0;
	int          fail_cnt = 0;
	int          stall_cycles = 0;

	// keys of the last loaded tables, used to aim queries at hits and near misses
	logic [31:0] gen_akey [$];
	logic [31:0] gen_lkey [$];

	line_address_table_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.entry_index(entry_index),
		.address(address),
		.line_number(line_number),
		.slide_direction(slide_direction),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found_line(found_line),
		.found_address(found_address)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// search key of one slot of the address-sorted or line-sorted table
	function automatic logic [31:0] entry_key(bit by_line, int slot);
		return by_line ? {8'h00, line_tab[slot].line} : addr_tab[slot].addr;
	endfunction

	// floor-midpoint binary search with the slide rule on a miss; -1 means answer zero
	function automatic int find_slot(bit by_line, logic [31:0] key, logic signed [1:0] slide);
		int cnt, lo, hi, mid, dir;
		logic [31:0] k;
		dir = slide;
		cnt = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
		if (!cfg_present || cnt == 0)
			return -1;
		lo = 0;
		hi = cnt - 1;
		if (key < entry_key(by_line, 0))
			return (dir > 0) ? 0 : -1;
		if (key > entry_key(by_line, hi))
			return (dir < 0) ? hi : -1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			k = entry_key(by_line, mid);
			if (k == key)
				return mid;
			if (k > key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		if (dir == 0)
			return -1;
		if (dir > 0)
			hi = hi + 1;
		if (hi < 0 || hi >= cnt)
			return -1;
		return hi;
	endfunction

	// update the table copies or queue the expected answer of one accepted item
	task automatic apply_item();
		answer_t ans;
		int slot;
		ans.line = '0;
		ans.addr = '0;
		case (operation)
			OP_WR_ADDR: begin
				addr_tab[entry_index].addr = address;
				addr_tab[entry_index].line = line_number;
			end
			OP_WR_LINE: begin
				line_tab[entry_index].addr = address;
				line_tab[entry_index].line = line_number;
			end
			OP_ADDR2LINE: begin
				slot = find_slot(1'b0, address - cfg_base, slide_direction);
				if (slot >= 0)
					ans.line = addr_tab[slot].line;
				answer_q.push_back(ans);
			end
			default: begin
				slot = find_slot(1'b1, {8'h00, line_number}, slide_direction);
				if (slot >= 0)
					ans.addr = line_tab[slot].addr + cfg_base;
				answer_q.push_back(ans);
			end
		endcase
	endtask

	// result check against the oldest answer, then prediction of the new transfer
	always @(posedge clk) begin
		answer_t exp_ans;
		in_done <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				$error("unexpected result: found_line %h found_address %h",
					found_line, found_address);
				fail_cnt++;
			end else begin
				exp_ans = answer_q.pop_front();
				if (found_line !== exp_ans.line) begin
					$error("found_line: expected %h, got %h", exp_ans.line, found_line);
					fail_cnt++;
				end
				if (found_address !== exp_ans.addr) begin
					$error("found_address: expected %h, got %h", exp_ans.addr, found_address);
					fail_cnt++;
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			apply_item();
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// sender and receiver, both changing on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_done)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				drv_cmd = cmd_q.pop_front();
				operation       <= drv_cmd.op;
				entry_index     <= drv_cmd.idx;
				address         <= drv_cmd.addr;
				line_number     <= drv_cmd.line;
				slide_direction <= drv_cmd.slide;
				in_valid        <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_gap_pct);
	end

	task automatic push_req(op_t op, logic [7:0] idx, logic [31:0] a, logic [23:0] l,
			logic signed [1:0] s);
		req_t r;
		r.op = op;
		r.idx = idx;
		r.addr = a;
		r.line = l;
		r.slide = s;
		cmd_q.push_back(r);
	endtask

	// wait until every item is taken and answered, then let the block settle
	task automatic wait_idle();
		do @(negedge clk);
		while (cmd_q.size() != 0 || in_valid || answer_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_TABLE_PRESENT: cfg_present = val[0];
			CFG_BASE_OFFSET:   cfg_base = val;
			CFG_ENTRY_COUNT:   cfg_count = val[8:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// fill slots 0..cnt-1 of both tables with sorted keys; narrow spreads give duplicates
	task automatic load_tables(int cnt, bit narrow);
		logic [31:0] a_keys [$];
		logic [31:0] l_keys [$];
		logic [31:0] lo_a;
		logic [23:0] lo_l;
		int i;
		lo_a = $urandom;
		lo_l = 24'($urandom);
		for (i = 0; i < cnt; i++) begin
			a_keys.push_back(narrow ? lo_a + $urandom_range(0, 2 * cnt) : $urandom);
			l_keys.push_back(narrow ? {8'h00, lo_l + 24'($urandom_range(0, 2 * cnt))}
				: {8'h00, 24'($urandom)});
		end
		a_keys.sort();
		l_keys.sort();
		for (i = 0; i < cnt; i++) begin
			push_req(OP_WR_ADDR, 8'(i), a_keys[i], 24'($urandom), 2'($urandom));
			push_req(OP_WR_LINE, 8'(i), $urandom, l_keys[i][23:0], 2'($urandom));
		end
		gen_akey = a_keys;
		gen_lkey = l_keys;
	endtask

	// query key: mostly a stored key, sometimes a neighbor, an extreme or anything
	function automatic logic [31:0] pick_key(logic [31:0] keys [$], logic [31:0] top);
		int sel;
		logic [31:0] k;
		sel = $urandom_range(9);
		if (sel == 7) begin
			k = $urandom_range(1) ? top : '0;
		end else if (keys.size() == 0 || sel >= 8) begin
			k = $urandom;
		end else begin
			k = keys[$urandom_range(keys.size() - 1)];
			if (sel == 6)
				k = $urandom_range(1) ? k + 1 : k - 1;
		end
		return k & top;
	endfunction

	// lookups of both kinds with a few stray table writes mixed in
	task automatic random_lookups(int n);
		int i;
		logic [31:0] k;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				push_req($urandom_range(1) ? OP_WR_LINE : OP_WR_ADDR, 8'($urandom),
					$urandom, 24'($urandom), 2'($urandom));
			end else if ($urandom_range(1)) begin
				k = pick_key(gen_akey, 32'hFFFF_FFFF);
				push_req(OP_ADDR2LINE, 8'($urandom), k + cfg_base, 24'($urandom),
					2'($urandom));
			end else begin
				k = pick_key(gen_lkey, 32'h00FF_FFFF);
				push_req(OP_LINE2ADDR, 8'($urandom), $urandom, k[23:0], 2'($urandom));
			end
		end
	endtask

	initial begin
		int p, cnt;
		logic [8:0] n_req;
		logic [31:0] base_req;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_gap_pct = 26;
		recv_gap_pct = 66;

		// table absent after reset: lookups answer zero
		push_req(OP_ADDR2LINE, 8'h00, 32'h0000_0000, 24'h000000, 2'sd1);
		push_req(OP_LINE2ADDR, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, -2'sd1);
		wait_idle();

		// small tables, each with one duplicate key
		write_reg(CFG_TABLE_PRESENT, 32'd1);
		write_reg(CFG_BASE_OFFSET, 32'd0);
		write_reg(CFG_ENTRY_COUNT, 32'd4);
		push_req(OP_WR_ADDR, 8'd0, 32'h100, 24'd10, 2'sd0);
		push_req(OP_WR_ADDR, 8'd1, 32'h200, 24'd20, 2'sd0);
		push_req(OP_WR_ADDR, 8'd2, 32'h200, 24'd25, 2'sd0);
		push_req(OP_WR_ADDR, 8'd3, 32'h300, 24'd30, 2'sd0);
		push_req(OP_WR_LINE, 8'd0, 32'h1000, 24'd5, 2'sd0);
		push_req(OP_WR_LINE, 8'd1, 32'h2000, 24'd7, 2'sd0);
		push_req(OP_WR_LINE, 8'd2, 32'h3000, 24'd9, 2'sd0);
		push_req(OP_WR_LINE, 8'd3, 32'h3100, 24'd9, 2'sd0);

		// exact hits, duplicates, below first, above last, misses in between
		push_req(OP_ADDR2LINE, 8'd0, 32'h200, 24'd0, 2'sd0);
		push_req(OP_ADDR2LINE, 8'd0, 32'h100, 24'd0, 2'sd0);
		push_req(OP_ADDR2LINE, 8'd0, 32'h050, 24'd0, 2'sd1);
		push_req(OP_ADDR2LINE, 8'd0, 32'h050, 24'd0, 2'sd0);
		push_req(OP_ADDR2LINE, 8'd0, 32'h400, 24'd0, -2'sd1);
		push_req(OP_ADDR2LINE, 8'd0, 32'h400, 24'd0, 2'sd1);
		push_req(OP_ADDR2LINE, 8'd0, 32'h250, 24'd0, -2'sd1);
		push_req(OP_ADDR2LINE, 8'd0, 32'h250, 24'd0, 2'sd1);
		push_req(OP_ADDR2LINE, 8'd0, 32'h250, 24'd0, 2'sd0);
		push_req(OP_ADDR2LINE, 8'd0, 32'hFFFF_FFFF, 24'd0, -2'sd2);
		push_req(OP_LINE2ADDR, 8'd0, 32'd0, 24'd0, 2'sd1);
		push_req(OP_LINE2ADDR, 8'd0, 32'd0, 24'd8, 2'sd1);
		push_req(OP_LINE2ADDR, 8'd0, 32'd0, 24'd6, -2'sd2);
		push_req(OP_LINE2ADDR, 8'd0, 32'd0, 24'hFF_FFFF, -2'sd1);
		push_req(OP_LINE2ADDR, 8'd0, 32'd0, 24'd9, 2'sd0);
		wait_idle();

		// random phases: each loads fresh tables under new register settings
		for (p = 0; p < 12; p++) begin
			send_gap_pct = (p < 4) ? 26 : (p < 8) ? 66 : 0;
			recv_gap_pct = (p < 4) ? 66 : (p < 8) ? 26 : 0;
			case (p)
				5: n_req = 9'd511;
				7: n_req = 9'd0;
				9: n_req = 9'd1;
				default: n_req = 9'($urandom_range(2, 24));
			endcase
			case (p)
				2: base_req = 32'hFFFF_FFFF;
				4: base_req = 32'h0000_0000;
				6: base_req = 32'h8000_0000;
				default: base_req = $urandom;
			endcase
			write_reg(CFG_TABLE_PRESENT, (p == 3) ? 32'd0 : 32'd1);
			write_reg(CFG_BASE_OFFSET, base_req);
			write_reg(CFG_ENTRY_COUNT, {23'd0, n_req});
			cnt = (n_req > DEPTH) ? DEPTH : int'(n_req);
			load_tables(cnt, p[0]);
			random_lookups(12);
			// sender holds off until all answers are back
			wait_idle();
			random_lookups(12);
			wait_idle();
		end

		if (fail_cnt == 0 && answer_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
